[rtl/core/vec_pkg.sv]
// Shared constants, types and helpers for the voxel Euler characteristic block.
// No dependencies; used by vec_nbr_store and voxel_euler_characteristic.
`timescale 1ns / 1ps

package vec_pkg;

   // Volume limits and position widths
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_DEPTH  = 256;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int ZW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // Field widths
   localparam int LABEL_W = 8;
   localparam int SIZE_W  = 9;
   localparam int EUL_W   = 29;
   localparam int PTS_W   = 25;
   localparam int EDG_W   = 26;
   localparam int FAC_W   = 26;
   localparam int CUB_W   = 25;

   localparam int REQ_DATA_W = ((LABEL_W + 7) / 8) * 8;
   localparam int RSP_BITS   = EUL_W + PTS_W + EDG_W + FAC_W + CUB_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD    = RSP_DATA_W - RSP_BITS;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LABEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH       = 2'd3;

   localparam logic [LABEL_W-1:0] MATCH_LABEL_RESET = 8'd1;
   localparam logic [SIZE_W-1:0]  SIZE_RESET        = 9'd256;

   // Write side of the neighbour stores
   typedef struct packed {
      logic          en;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic          set;
      logic          pv;
   } wr_type;

   // Registered neighbour data for the item in the work stage
   typedef struct packed {
      logic prev_bit;   // same (x,y) in the previous plane
      logic row_set;    // voxel one row up
      logic row_pv;     // previous-plane bit of the voxel one row up
   } rd_type;

   // Last position index for a size: zero acts as one, above the maximum clamps
   function automatic logic [SIZE_W+3:0] last_index(logic [SIZE_W-1:0] v, int unsigned maxv);
      logic [SIZE_W+3:0] r;
      if (v == '0) begin
         r = '0;
      end else if (32'(v) > maxv) begin
         r = (SIZE_W+4)'(maxv - 1);
      end else begin
         r = (SIZE_W+4)'(v) - (SIZE_W+4)'(1);
      end
      return r;
   endfunction

endpackage

[rtl/core/voxel_euler_characteristic.sv]
// Euler characteristic of a streamed binary volume: one voxel label per cycle, back to back.
// Each result is registered; a volume's last voxel waits while rsp holds an untaken result.
// Throughput: one voxel per cycle, set by one neighbour store read and one write per cycle.
// Reset: counts, positions and sizes return to defaults at once; the stores are not swept,
// the first plane reads the previous plane as empty. Uses vec_pkg and vec_nbr_store.
`timescale 1ns / 1ps

module voxel_euler_characteristic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vec_pkg::REQ_DATA_W-1:0]      req_tdata,   // voxel_label
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // euler_number, point_count, edge_count, face_count, cube_count, zero pad
   output logic [vec_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [vec_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vec_pkg::SIZE_W-1:0]          csr_wdata
);

   // configuration
   logic [vec_pkg::LABEL_W-1:0] match_ff, match_in;
   logic [vec_pkg::XW-1:0]      w_last_ff, w_last_in;
   logic [vec_pkg::YW-1:0]      h_last_ff, h_last_in;
   logic [vec_pkg::ZW-1:0]      d_last_ff, d_last_in;
   logic                        restart;

   // positions of the next item
   logic [vec_pkg::XW-1:0] x_ff, x_in;
   logic [vec_pkg::YW-1:0] y_ff, y_in;
   logic [vec_pkg::ZW-1:0] z_ff, z_in;
   logic                   x_end, y_end, z_end;

   // work stage
   logic                        s1_valid_ff, s1_valid_in;
   logic [vec_pkg::LABEL_W-1:0] s1_label_ff;
   logic [vec_pkg::XW-1:0]      s1_x_ff;
   logic [vec_pkg::YW-1:0]      s1_y_ff;
   logic                        s1_z_nz_ff;
   logic                        s1_last_ff;
   logic                        s1_fire;
   logic                        req_accept;

   logic [3:0] left_ff, left_in;

   // accumulators
   logic [vec_pkg::PTS_W-1:0] pts_ff, pts_in, pts_sum;
   logic [vec_pkg::EDG_W-1:0] edg_ff, edg_in, edg_sum;
   logic [vec_pkg::FAC_W-1:0] fac_ff, fac_in, fac_sum;
   logic [vec_pkg::CUB_W-1:0] cub_ff, cub_in, cub_sum;
   logic [vec_pkg::EUL_W-1:0] eul_ff, eul_in, eul_sum;

   // result register
   logic                      out_valid_ff, out_valid_in;
   logic                      out_free;
   logic [vec_pkg::EUL_W-1:0] out_eul_ff;
   logic [vec_pkg::PTS_W-1:0] out_pts_ff;
   logic [vec_pkg::EDG_W-1:0] out_edg_ff;
   logic [vec_pkg::FAC_W-1:0] out_fac_ff;
   logic [vec_pkg::CUB_W-1:0] out_cub_ff;

   // neighbour terms
   logic set, pv, cu, pu, cl, pl, cul, pul, counted;
   logic fxy, fxz, fyz, cube;
   logic [1:0] e_inc, f_inc;

   vec_pkg::wr_type st_wr;
   vec_pkg::rd_type st_rd;

   vec_nbr_store u_store (
      .clock (clock),
      .rd_en (req_accept),
      .rd_x  (x_ff),
      .rd_y  (y_ff),
      .wr    (st_wr),
      .rd    (st_rd)
   );

   // handshake
   assign out_free    = !out_valid_ff || rsp_tready;
   assign s1_fire     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready  = !s1_valid_ff || s1_fire;
   assign req_accept  = req_tvalid && req_tready;

   // configuration writes
   always_comb begin
      match_in  = match_ff;
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      d_last_in = d_last_ff;
      restart   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            vec_pkg::CSR_MATCH_LABEL: begin
               match_in = csr_wdata[vec_pkg::LABEL_W-1:0];
            end
            vec_pkg::CSR_WIDTH: begin
               w_last_in = vec_pkg::XW'(vec_pkg::last_index(csr_wdata, vec_pkg::MAX_WIDTH));
               restart   = 1'b1;
            end
            vec_pkg::CSR_HEIGHT: begin
               h_last_in = vec_pkg::YW'(vec_pkg::last_index(csr_wdata, vec_pkg::MAX_HEIGHT));
               restart   = 1'b1;
            end
            vec_pkg::CSR_DEPTH: begin
               d_last_in = vec_pkg::ZW'(vec_pkg::last_index(csr_wdata, vec_pkg::MAX_DEPTH));
               restart   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // raster position advance
   assign x_end = (x_ff == w_last_ff);
   assign y_end = (y_ff == h_last_ff);
   assign z_end = (z_ff == d_last_ff);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (restart) begin
         x_in = '0;
         y_in = '0;
         z_in = '0;
      end else if (req_accept) begin
         x_in = x_end ? '0 : x_ff + vec_pkg::XW'(1);
         if (x_end) begin
            y_in = y_end ? '0 : y_ff + vec_pkg::YW'(1);
            if (y_end) begin
               z_in = z_end ? '0 : z_ff + vec_pkg::ZW'(1);
            end
         end
      end
   end

   // neighbour terms of the item in the work stage
   always_comb begin
      set     = (s1_label_ff == match_ff);
      pv      = s1_z_nz_ff && st_rd.prev_bit;
      cu      = (s1_y_ff != '0) && st_rd.row_set;
      pu      = (s1_y_ff != '0) && st_rd.row_pv;
      cl      = left_ff[0];
      pl      = left_ff[1];
      cul     = left_ff[2];
      pul     = left_ff[3];
      counted = (s1_x_ff != '0) && (s1_y_ff != '0) && set;
      fxy     = cl && cu && cul;
      fxz     = cl && pv && pl;
      fyz     = cu && pv && pu;
      cube    = fxy && pv && pl && pu && pul;
      e_inc   = 2'(cl) + 2'(cu) + 2'(pv);
      f_inc   = 2'(fxy) + 2'(fxz) + 2'(fyz);
   end

   assign st_wr.en  = s1_fire;
   assign st_wr.x   = s1_x_ff;
   assign st_wr.y   = s1_y_ff;
   assign st_wr.set = set;
   assign st_wr.pv  = pv;

   // totals including the current item
   always_comb begin
      pts_sum = pts_ff;
      edg_sum = edg_ff;
      fac_sum = fac_ff;
      cub_sum = cub_ff;
      eul_sum = eul_ff;
      if (counted) begin
         pts_sum = pts_ff + vec_pkg::PTS_W'(1);
         edg_sum = edg_ff + vec_pkg::EDG_W'(e_inc);
         fac_sum = fac_ff + vec_pkg::FAC_W'(f_inc);
         cub_sum = cub_ff + vec_pkg::CUB_W'(cube);
         // running 2*(P-E+F-C)
         eul_sum = eul_ff + vec_pkg::EUL_W'(2) - vec_pkg::EUL_W'({e_inc, 1'b0})
                 + vec_pkg::EUL_W'({f_inc, 1'b0}) - vec_pkg::EUL_W'({cube, 1'b0});
      end
   end

   always_comb begin
      pts_in  = pts_ff;
      edg_in  = edg_ff;
      fac_in  = fac_ff;
      cub_in  = cub_ff;
      eul_in  = eul_ff;
      left_in = left_ff;
      if (restart) begin
         pts_in  = '0;
         edg_in  = '0;
         fac_in  = '0;
         cub_in  = '0;
         eul_in  = '0;
         left_in = '0;
      end else if (s1_fire) begin
         left_in = {pu, cu, pv, set};
         if (s1_last_ff) begin
            // volume done: drop the counts for the next volume
            pts_in = '0;
            edg_in = '0;
            fac_in = '0;
            cub_in = '0;
            eul_in = '0;
         end else begin
            pts_in = pts_sum;
            edg_in = edg_sum;
            fac_in = fac_sum;
            cub_in = cub_sum;
            eul_in = eul_sum;
         end
      end
   end

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign out_valid_in = (s1_fire && s1_last_ff) ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff     <= vec_pkg::MATCH_LABEL_RESET;
         w_last_ff    <= vec_pkg::XW'(vec_pkg::last_index(vec_pkg::SIZE_RESET,
                                                         vec_pkg::MAX_WIDTH));
         h_last_ff    <= vec_pkg::YW'(vec_pkg::last_index(vec_pkg::SIZE_RESET,
                                                         vec_pkg::MAX_HEIGHT));
         d_last_ff    <= vec_pkg::ZW'(vec_pkg::last_index(vec_pkg::SIZE_RESET,
                                                         vec_pkg::MAX_DEPTH));
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         left_ff      <= '0;
         pts_ff       <= '0;
         edg_ff       <= '0;
         fac_ff       <= '0;
         cub_ff       <= '0;
         eul_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         match_ff     <= match_in;
         w_last_ff    <= w_last_in;
         h_last_ff    <= h_last_in;
         d_last_ff    <= d_last_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         s1_valid_ff  <= s1_valid_in;
         left_ff      <= left_in;
         pts_ff       <= pts_in;
         edg_ff       <= edg_in;
         fac_ff       <= fac_in;
         cub_ff       <= cub_in;
         eul_ff       <= eul_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_label_ff <= req_tdata[vec_pkg::LABEL_W-1:0];
         s1_x_ff     <= x_ff;
         s1_y_ff     <= y_ff;
         s1_z_nz_ff  <= (z_ff != '0);
         s1_last_ff  <= x_end && y_end && z_end;
      end
      if (s1_fire && s1_last_ff) begin
         out_eul_ff <= eul_sum;
         out_pts_ff <= pts_sum;
         out_edg_ff <= edg_sum;
         out_fac_ff <= fac_sum;
         out_cub_ff <= cub_sum;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{vec_pkg::RSP_PAD{1'b0}}, out_cub_ff, out_fac_ff, out_edg_ff,
                        out_pts_ff, out_eul_ff};

endmodule

[rtl/core/vec_nbr_store.sv]
// Neighbour stores: previous-plane bit per (x,y) and row-above bits per x.
// Registered reads with forwarding of the write issued in the same cycle. Uses vec_pkg.
`timescale 1ns / 1ps

module vec_nbr_store (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [vec_pkg::XW-1:0]  rd_x,
   input  logic [vec_pkg::YW-1:0]  rd_y,
   input  vec_pkg::wr_type         wr,
   output vec_pkg::rd_type         rd
);

   localparam int PLANE_DEPTH = 2 ** (vec_pkg::XW + vec_pkg::YW);
   localparam int ROW_DEPTH   = 2 ** vec_pkg::XW;

   logic       plane_mem [PLANE_DEPTH];
   logic [1:0] row_mem   [ROW_DEPTH];

   logic       plane_q_ff;
   logic [1:0] row_q_ff;
   logic       fwd_plane_ff;
   logic       fwd_row_ff;
   logic       fwd_set_ff;
   logic       fwd_pv_ff;

   // Contents are not cleared: previous-plane reads are masked in the first plane,
   // and row-above reads are masked in the first row.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         plane_mem[{wr.y, wr.x}] <= wr.set;
         row_mem[wr.x]           <= {wr.pv, wr.set};
      end
      if (rd_en) begin
         plane_q_ff   <= plane_mem[{rd_y, rd_x}];
         row_q_ff     <= row_mem[rd_x];
         // the read sees old data when the item ahead writes the same entry now
         fwd_plane_ff <= wr.en && (wr.x == rd_x) && (wr.y == rd_y);
         fwd_row_ff   <= wr.en && (wr.x == rd_x);
         fwd_set_ff   <= wr.set;
         fwd_pv_ff    <= wr.pv;
      end
   end

   always_comb begin
      rd.prev_bit = fwd_plane_ff ? fwd_set_ff : plane_q_ff;
      rd.row_set  = fwd_row_ff   ? fwd_set_ff : row_q_ff[0];
      rd.row_pv   = fwd_row_ff   ? fwd_pv_ff  : row_q_ff[1];
   end

endmodule

[dv/voxel_euler_characteristic_tb.sv]
// Self-checking testbench for voxel_euler_characteristic: streams voxel labels through random
// stalls and checks every result against a cycle-free model of the neighbour counts.
// Depends on vec_pkg and the voxel_euler_characteristic RTL.
`timescale 1ns / 1ps

module voxel_euler_characteristic_tb;

   localparam int IDLE_LIMIT = 2000;

   // One result, euler field in the lowest bits
   typedef struct packed {
      logic [vec_pkg::CUB_W-1:0] cubes;
      logic [vec_pkg::FAC_W-1:0] faces;
      logic [vec_pkg::EDG_W-1:0] edges;
      logic [vec_pkg::PTS_W-1:0] points;
      logic [vec_pkg::EUL_W-1:0] euler;
   } totals_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [vec_pkg::REQ_DATA_W-1:0]   req_tdata = '0;     // voxel_label
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // euler_number, point_count, edge_count, face_count, cube_count, zero pad
   logic [vec_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [vec_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [vec_pkg::SIZE_W-1:0]       csr_wdata = '0;

   voxel_euler_characteristic uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Volume model state
   bit                          prev_plane [0:vec_pkg::MAX_WIDTH*vec_pkg::MAX_HEIGHT-1];
   bit [1:0]                    row_above [0:vec_pkg::MAX_WIDTH-1];
   bit [3:0]                    left_bits;
   int unsigned                 pos_x, pos_y, pos_z;
   bit [vec_pkg::PTS_W-1:0]     point_tally;
   bit [vec_pkg::EDG_W-1:0]     n_edges [3];
   bit [vec_pkg::FAC_W-1:0]     n_faces [3];
   bit [vec_pkg::CUB_W-1:0]     n_cubes;
   bit [vec_pkg::LABEL_W-1:0]   match_lbl;
   bit [vec_pkg::SIZE_W-1:0]    size_x, size_y, size_z;

   totals_type                  expected_totals [$];
   logic [vec_pkg::LABEL_W-1:0] label_queue [$];

   int  mismatches = 0;
   int  idle_cycles = 0;
   int  voxels_queued = 0;
   int  volumes_queued = 0;
   bit  req_fire = 1'b0;
   bit  quiet_tail = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   int  stall_request = 0;

   function automatic int unsigned eff_size(logic [vec_pkg::SIZE_W-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic int unsigned volume_len();
      return eff_size(size_x, vec_pkg::MAX_WIDTH) * eff_size(size_y, vec_pkg::MAX_HEIGHT)
             * eff_size(size_z, vec_pkg::MAX_DEPTH);
   endfunction

   function automatic void clear_volume();
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
      left_bits = '0;
      point_tally = '0;
      n_cubes = '0;
      foreach (n_edges[i]) n_edges[i] = '0;
      foreach (n_faces[i]) n_faces[i] = '0;
   endfunction

   function automatic void apply_csr(logic [vec_pkg::CSR_IDX_W-1:0] idx,
                                     logic [vec_pkg::SIZE_W-1:0] data);
      case (idx)
         vec_pkg::CSR_MATCH_LABEL: match_lbl = data[vec_pkg::LABEL_W-1:0];
         vec_pkg::CSR_WIDTH: begin
            size_x = data;
            clear_volume();
         end
         vec_pkg::CSR_HEIGHT: begin
            size_y = data;
            clear_volume();
         end
         vec_pkg::CSR_DEPTH: begin
            size_z = data;
            clear_volume();
         end
         default: ;
      endcase
   endfunction

   // Add one voxel to the running counts; queue the totals at the end of a volume
   function automatic void tally_voxel(logic [vec_pkg::LABEL_W-1:0] label);
      int unsigned w, h, d, x, y;
      bit          set, pv, cu, pu, cl, pl, cul, pul, fxy;
      totals_type  t;
      w = eff_size(size_x, vec_pkg::MAX_WIDTH);
      h = eff_size(size_y, vec_pkg::MAX_HEIGHT);
      d = eff_size(size_z, vec_pkg::MAX_DEPTH);
      if (pos_x >= w) pos_x = 0;
      if (pos_y >= h) pos_y = 0;
      if (pos_z >= d) pos_z = 0;
      x = pos_x;
      y = pos_y;
      set = (label == match_lbl);
      // first plane of a volume sees an empty plane before it
      pv = (pos_z != 0) && prev_plane[y*vec_pkg::MAX_WIDTH + x];
      cu = 1'b0;
      pu = 1'b0;
      if (y > 0) begin
         cu = row_above[x][0];
         pu = row_above[x][1];
      end
      {pul, cul, pl, cl} = left_bits;
      if (x > 0 && y > 0 && set) begin
         fxy = cl && cu && cul;
         point_tally++;
         n_edges[0] += vec_pkg::EDG_W'(cl);
         n_edges[1] += vec_pkg::EDG_W'(cu);
         n_edges[2] += vec_pkg::EDG_W'(pv);
         if (fxy) n_faces[0]++;
         if (cl && pv && pl) n_faces[1]++;
         if (cu && pv && pu) n_faces[2]++;
         if (fxy && pv && pl && pu && pul) n_cubes++;
      end
      left_bits = {pu, cu, pv, set};
      row_above[x] = {pv, set};
      prev_plane[y*vec_pkg::MAX_WIDTH + x] = set;

      if (x + 1 < w) begin
         pos_x = x + 1;
      end else begin
         pos_x = 0;
         if (y + 1 < h) begin
            pos_y = y + 1;
         end else begin
            pos_y = 0;
            if (pos_z + 1 < d) begin
               pos_z++;
            end else begin
               t.edges  = n_edges[0] + n_edges[1] + n_edges[2];
               t.faces  = n_faces[0] + n_faces[1] + n_faces[2];
               t.points = point_tally;
               t.cubes  = n_cubes;
               t.euler  = vec_pkg::EUL_W'(2 * (longint'(point_tally) - t.edges + t.faces
                                               - n_cubes));
               expected_totals.push_back(t);
               clear_volume();
            end
         end
      end
   endfunction

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Sample everything at the rising edge
   always @(posedge clock) begin
      totals_type got, want;
      bit         rsp_fire;
      req_fire = req_tvalid && req_tready;
      rsp_fire = rsp_tvalid && rsp_tready;
      if (reset) begin
         req_fire = 1'b0;
         foreach (prev_plane[i]) prev_plane[i] = 1'b0;
         foreach (row_above[i]) row_above[i] = '0;
         match_lbl = vec_pkg::MATCH_LABEL_RESET;
         size_x = vec_pkg::SIZE_RESET;
         size_y = vec_pkg::SIZE_RESET;
         size_z = vec_pkg::SIZE_RESET;
         clear_volume();
         idle_cycles = 0;
      end else begin
         if (rsp_fire) begin
            got = totals_type'(rsp_tdata[vec_pkg::RSP_BITS-1:0]);
            if (expected_totals.size() == 0) begin
               $error("unexpected result: euler_number %0d", $signed(got.euler));
               mismatches++;
            end else begin
               want = expected_totals.pop_front();
               compare_field("euler_number", $signed(want.euler), $signed(got.euler));
               compare_field("point_count", want.points, got.points);
               compare_field("edge_count", want.edges, got.edges);
               compare_field("face_count", want.faces, got.faces);
               compare_field("cube_count", want.cubes, got.cubes);
               compare_field("tdata pad", 0,
                             rsp_tdata[vec_pkg::RSP_DATA_W-1:vec_pkg::RSP_BITS]);
            end
         end
         if (csr_we) apply_csr(csr_index, csr_wdata);
         if (req_fire) tally_voxel(req_tdata[vec_pkg::LABEL_W-1:0]);
         if (req_fire || rsp_fire || csr_we) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // Voxel sender: random idle bursts between items
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
            req_tvalid <= 1'b0;
         end else if (label_queue.size() != 0) begin
            req_tdata <= label_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus one long hold on request
   always @(negedge clock) begin
      if (stall_request != 0) begin
         hold_left = stall_request;
         stall_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
         recv_gap = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_csr(logic [vec_pkg::CSR_IDX_W-1:0] idx,
                            logic [vec_pkg::SIZE_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_volume(logic [vec_pkg::SIZE_W-1:0] w, logic [vec_pkg::SIZE_W-1:0] h,
                             logic [vec_pkg::SIZE_W-1:0] d);
      write_csr(vec_pkg::CSR_WIDTH, w);
      write_csr(vec_pkg::CSR_HEIGHT, h);
      write_csr(vec_pkg::CSR_DEPTH, d);
   endtask

   task automatic queue_label(logic [vec_pkg::LABEL_W-1:0] label);
      label_queue.push_back(label);
      voxels_queued++;
   endtask

   // density: percent of voxels that carry the match label
   task automatic queue_voxels(int unsigned count, int unsigned density);
      repeat (count) begin
         if ($urandom_range(0, 99) < density) queue_label(match_lbl);
         else queue_label(vec_pkg::LABEL_W'($urandom_range(0, 255)));
      end
   endtask

   // Hold until every item is in and every result is out, then let the pipe settle
   task automatic drain_block();
      while (label_queue.size() != 0 || req_tvalid || expected_totals.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int          phase;
      int unsigned nvol, dens, part;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Solid 2x2x2 volume of label 255: one full cube
      write_csr(vec_pkg::CSR_MATCH_LABEL, 9'h1FF);
      set_volume(2, 2, 2);
      repeat (8) queue_label(8'hFF);
      volumes_queued++;
      // Abandon a volume part way: a size write restarts it
      queue_label(8'hFF);
      queue_label(8'h00);
      drain_block();
      write_csr(vec_pkg::CSR_DEPTH, 2);
      // Changing the label mid-volume keeps the counts
      queue_label(8'hFF);
      queue_label(8'h00);
      queue_label(8'hFF);
      queue_label(8'hFF);
      drain_block();
      write_csr(vec_pkg::CSR_MATCH_LABEL, 9'h000);
      queue_label(8'h00);
      queue_label(8'h00);
      queue_label(8'hFE);
      queue_label(8'h00);
      volumes_queued++;
      // Zero sizes act as one: every voxel closes a volume
      drain_block();
      set_volume(0, 0, 0);
      queue_label(8'h00);
      queue_label(8'hFF);
      volumes_queued += 2;

      phase = 0;
      while (voxels_queued < 1400 || volumes_queued < 48) begin
         drain_block();
         if ($urandom_range(0, 1))
            write_csr(vec_pkg::CSR_MATCH_LABEL, vec_pkg::SIZE_W'($urandom_range(0, 511)));
         case (phase)
            1: begin
               // one-voxel volumes against a long receiver hold: fill the block
               set_volume(1, 0, 1);
               stall_request = 200;
               queue_voxels(40, 50);
               volumes_queued += 40;
            end
            3: begin
               set_volume(9'h1FF, 2, 1);
               queue_voxels(volume_len(), 85);
               volumes_queued++;
            end
            6: begin
               set_volume(1, 9'h100, 0);
               queue_voxels(volume_len(), 60);
               volumes_queued++;
            end
            9: begin
               set_volume(1, 1, 9'h140);
               queue_voxels(volume_len(), 60);
               volumes_queued++;
            end
            default: begin
               set_volume(vec_pkg::SIZE_W'($urandom_range(0, 5)),
                          vec_pkg::SIZE_W'($urandom_range(0, 5)),
                          vec_pkg::SIZE_W'($urandom_range(0, 4)));
               nvol = $urandom_range(1, 3);
               dens = $urandom_range(30, 95);
               repeat (nvol) queue_voxels(volume_len(), dens);
               volumes_queued += nvol;
               // leave a broken volume behind now and then
               if ($urandom_range(0, 4) == 0) begin
                  part = $urandom_range(0, volume_len() - 1);
                  queue_voxels(part, dens);
               end
            end
         endcase
         phase++;
      end

      // Closing stretch without idling on either side
      drain_block();
      quiet_tail = 1'b1;
      write_csr(vec_pkg::CSR_MATCH_LABEL, 9'd7);
      set_volume(3, 3, 3);
      queue_voxels(2 * volume_len(), 80);
      volumes_queued += 2;

      drain_block();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/vec_pkg.sv
rtl/core/vec_nbr_store.sv
rtl/core/voxel_euler_characteristic.sv
dv/voxel_euler_characteristic_tb.sv
